// ===== rtl/npsa_pkg.sv =====
// Package for the nearest point search: shared types and constants.
// Used by npsa_ctrl, npsa_dp and the top level; no dependencies.
package npsa_pkg;
	localparam int unsigned DIST_BITS = 49;
	localparam int unsigned IDX_BITS = 11;
	localparam int unsigned CFG_IDX_BITS = 1;
	// starting limit: 1e9 in 16-fraction-bit units
	localparam logic [DIST_BITS-1:0] START_LIMIT = 49'd65536000000000;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;
	localparam logic [CFG_IDX_BITS-1:0] REG_POINTS = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_AXIS = 1'b1;

	// datapath operation selects, driven by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LATCH,   // capture query / init binary search
		OP_BSTEP,   // evaluate one binary search probe
		OP_SCAN,    // evaluate one scan probe
		OP_ID,      // read winning id
		OP_OUT      // unused; npsa_dp takes no action on it
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   rd;       // issue memory read at current address
		logic   scan_up;  // scan direction for OP_SCAN / setup
		logic   scan_init;// set scan pointer to mid (down) or mid+1 (up)
		logic   load;     // write a load transaction
		logic   done;     // result strobe flag; npsa_dp does not use it
	} dp_cmd_t;

	typedef struct packed {
		logic bs_done;    // binary search finished
		logic scan_stop;  // current side must stop
		logic down_last;  // down pointer at slot zero
		logic up_empty;   // mid+1 is past the line end
		logic up_last;    // up pointer at last slot
	} dp_sts_t;
endpackage

// ===== rtl/nearest_point_sorted_axis_search.sv =====
// Nearest point search on sorted 2-D lines; top level.
// Query: binary search (last probe runs twice), scan down from mid, then scan up
// from mid+1 unless past the line end; then the winning id and point are read.
// busy drops the cycle after done; loads keep busy low and go one per cycle.
// Each probe is a read state then an evaluate state, as the memory has one read port.
// arst_n resets control and config; memories are undefined until loaded; no stall.
module nearest_point_sorted_axis_search #(
	parameter int unsigned COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [2:0]                    line_number,
	input  logic [7:0]                    sorted_slot,
	input  logic [7:0]                    point_id,
	input  logic signed [COORD_BITS-1:0]  coord_x,
	input  logic signed [COORD_BITS-1:0]  coord_y,
	input  logic signed [COORD_BITS-1:0]  coord_z,
	input  logic [10:0]                   previous_index,
	output logic                          done,
	output logic [10:0]                   nearest_index,
	output logic signed [COORD_BITS-1:0]  nearest_x,
	output logic signed [COORD_BITS-1:0]  nearest_y,
	output logic signed [COORD_BITS-1:0]  nearest_z,
	output logic [48:0]                   distance_squared,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [0:0]                    cfg_index,
	input  logic [8:0]                    cfg_data
);
	npsa_pkg::dp_cmd_t dcmd;
	npsa_pkg::dp_sts_t sts;
	logic [8:0] points_q, n_eff;
	logic       axis_q, ctl_busy, tail_busy, accept;
	logic [2:0] line_q;
	logic [7:0] slot_q, pid_q;
	logic signed [COORD_BITS-1:0] x_q, y_q, z_q;
	logic [10:0] prev_q;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= 9'd256;
			axis_q <= 1'b1;
		end else if (cfg_valid) begin
			if (cfg_index == npsa_pkg::REG_POINTS) points_q <= cfg_data;
			else if (cfg_index == npsa_pkg::REG_AXIS) axis_q <= cfg_data[0];
		end
	end
	assign n_eff = (points_q == '0) ? 9'd1 : ((points_q > 9'd256) ? 9'd256 : points_q);

	// input transaction held from acceptance until the datapath takes it
	assign accept = start && !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
			slot_q <= '0;
			pid_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			prev_q <= '0;
		end else if (accept) begin
			line_q <= line_number;
			slot_q <= sorted_slot;
			pid_q <= point_id;
			x_q <= coord_x;
			y_q <= coord_y;
			z_q <= coord_z;
			prev_q <= previous_index;
		end
	end

	npsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(accept), .cmd(cmd),
		.line_ok(1'b1), .sts(sts), .dcmd(dcmd), .busy(ctl_busy)
	);

	// hold busy through the result tail
	logic [3:0] tail_cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tail_cnt_q <= '0;
		else if (dcmd.op == npsa_pkg::OP_ID) tail_cnt_q <= 4'd4;
		else if (tail_cnt_q != '0) tail_cnt_q <= tail_cnt_q - 1'b1;
	end
	assign tail_busy = (tail_cnt_q != '0) || (dcmd.op == npsa_pkg::OP_ID);
	assign busy = ctl_busy || tail_busy || (dcmd.op == npsa_pkg::OP_LATCH);

	npsa_dp #(.LINE_BITS(3), .SLOT_BITS(8), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .dcmd(dcmd), .sts(sts), .n_pts(n_eff), .onx(axis_q),
		.line_in(line_q), .slot_in(slot_q), .id_in(pid_q),
		.x_in(x_q), .y_in(y_q), .z_in(z_q), .prev_in(prev_q),
		.res_valid(done), .res_index(nearest_index), .res_x(nearest_x),
		.res_y(nearest_y), .res_z(nearest_z), .res_dist(distance_squared)
	);
endmodule

// ===== rtl/npsa_ctrl.sv =====
// Controller state machine of the nearest point search.
// Depends on npsa_pkg; sequences npsa_dp through command/status structs.
module npsa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cmd,
	input  logic               line_ok,
	input  npsa_pkg::dp_sts_t  sts,
	output npsa_pkg::dp_cmd_t  dcmd,
	output logic               busy
);
	typedef enum logic [3:0] {
		S_IDLE, S_BRD, S_BEV, S_DRD, S_DEV, S_URD, S_UEV, S_IRD, S_IEV, S_PRD, S_PEV
	} state_t;
	state_t state_q;

	assign busy = (state_q != S_IDLE);

	// state and command decode in one clocked block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dcmd <= '0;
		end else begin
			dcmd <= '0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd == npsa_pkg::CMD_LOAD) begin
							dcmd.load <= 1'b1;
						end else if (line_ok) begin
							dcmd.op <= npsa_pkg::OP_LATCH;
							state_q <= S_BRD;
						end
					end
				end
				S_BRD: begin
					dcmd.rd <= 1'b1;
					state_q <= S_BEV;
				end
				S_BEV: begin
					dcmd.op <= npsa_pkg::OP_BSTEP;
					state_q <= S_DRD;
				end
				S_DRD: begin
					if (sts.bs_done) begin
						dcmd.scan_init <= 1'b1;
						state_q <= S_DEV;
					end else begin
						dcmd.rd <= 1'b1;
						state_q <= S_BEV;
					end
				end
				S_DEV: begin
					// read issued at pointer, evaluate next cycle
					dcmd.rd <= 1'b1;
					state_q <= S_URD;
				end
				S_URD: begin
					dcmd.op <= npsa_pkg::OP_SCAN;
					state_q <= S_UEV;
				end
				S_UEV: begin
					if (sts.scan_stop || sts.down_last) begin
						if (sts.up_empty) begin
							state_q <= S_IRD;
						end else begin
							dcmd.scan_init <= 1'b1;
							dcmd.scan_up <= 1'b1;
							state_q <= S_IEV;
						end
					end else begin
						dcmd.rd <= 1'b1;
						state_q <= S_URD;
					end
				end
				S_IEV: begin
					dcmd.rd <= 1'b1;
					dcmd.scan_up <= 1'b1;
					state_q <= S_PRD;
				end
				S_PRD: begin
					dcmd.op <= npsa_pkg::OP_SCAN;
					dcmd.scan_up <= 1'b1;
					state_q <= S_PEV;
				end
				S_PEV: begin
					if (sts.scan_stop || sts.up_last) begin
						state_q <= S_IRD;
					end else begin
						dcmd.rd <= 1'b1;
						dcmd.scan_up <= 1'b1;
						state_q <= S_PRD;
					end
				end
				S_IRD: begin
					dcmd.op <= npsa_pkg::OP_ID;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// id read then point read then result are chained in the datapath
		end
	end
endmodule

// ===== rtl/npsa_dp.sv =====
// Datapath of the nearest point search: point memories, search registers,
// distance arithmetic. Depends on npsa_pkg; driven by npsa_ctrl.
module npsa_dp #(
	parameter int unsigned LINE_BITS = 3,
	parameter int unsigned SLOT_BITS = 8,
	parameter int unsigned COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  npsa_pkg::dp_cmd_t             dcmd,
	output npsa_pkg::dp_sts_t             sts,
	input  logic [SLOT_BITS:0]            n_pts,
	input  logic                          onx,
	input  logic [LINE_BITS-1:0]          line_in,
	input  logic [SLOT_BITS-1:0]          slot_in,
	input  logic [SLOT_BITS-1:0]          id_in,
	input  logic signed [COORD_BITS-1:0]  x_in,
	input  logic signed [COORD_BITS-1:0]  y_in,
	input  logic signed [COORD_BITS-1:0]  z_in,
	input  logic [npsa_pkg::IDX_BITS-1:0] prev_in,
	output logic                          res_valid,
	output logic [npsa_pkg::IDX_BITS-1:0] res_index,
	output logic signed [COORD_BITS-1:0]  res_x,
	output logic signed [COORD_BITS-1:0]  res_y,
	output logic signed [COORD_BITS-1:0]  res_z,
	output logic [npsa_pkg::DIST_BITS-1:0] res_dist
);
	localparam int unsigned AW = LINE_BITS + SLOT_BITS;
	localparam int unsigned DEPTH = 1 << AW;
	localparam int unsigned SQW = 2 * COORD_BITS + 2;
	localparam int unsigned DW = npsa_pkg::DIST_BITS;

	// memories
	logic signed [COORD_BITS-1:0] mem_sx [DEPTH];
	logic signed [COORD_BITS-1:0] mem_sz [DEPTH];
	logic [SLOT_BITS-1:0]         mem_id [DEPTH];
	logic [3*COORD_BITS-1:0]      mem_pt [DEPTH];

	logic signed [COORD_BITS-1:0] rd_x_q, rd_z_q;
	logic [SLOT_BITS-1:0]         rd_id_q;
	logic [3*COORD_BITS-1:0]      rd_pt_q;

	// query registers
	logic [LINE_BITS-1:0]          line_q;
	logic signed [COORD_BITS-1:0]  qx_q, qz_q;
	logic [npsa_pkg::IDX_BITS-1:0] prev_q;
	logic [SLOT_BITS-1:0]          lo_q, hi_q, mid_q, ptr_q, best_slot_q, fid_q;
	logic [SQW-1:0]                best_q;
	logic                          bs_done_q;
	logic [2:0]                    tail_q;

	logic [SLOT_BITS-1:0] rd_slot;
	logic                 id_phase;
	assign rd_slot = dcmd.rd ? ptr_q : best_slot_q;

	// memory ports: one write, one registered read
	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			mem_sx[{line_in, slot_in}] <= x_in;
			mem_sz[{line_in, slot_in}] <= z_in;
			mem_id[{line_in, slot_in}] <= id_in;
			mem_pt[{line_in, id_in}] <= {x_in, y_in, z_in};
		end
		rd_x_q <= mem_sx[{line_q, rd_slot}];
		rd_z_q <= mem_sz[{line_q, rd_slot}];
		rd_id_q <= mem_id[{line_q, rd_slot}];
		rd_pt_q <= mem_pt[{line_q, fid_q}];
	end

	// distance terms of the probe just read
	logic signed [COORD_BITS:0] dx, dz;
	logic [SQW-1:0] sqx, sqz, ax, dd;
	assign dx = {rd_x_q[COORD_BITS-1], rd_x_q} - {qx_q[COORD_BITS-1], qx_q};
	assign dz = {rd_z_q[COORD_BITS-1], rd_z_q} - {qz_q[COORD_BITS-1], qz_q};
	assign sqx = SQW'(dx * dx);
	assign sqz = SQW'(dz * dz);
	assign ax = onx ? sqx : sqz;
	assign dd = sqx + sqz;

	logic signed [COORD_BITS-1:0] v, q;
	assign v = onx ? rd_x_q : rd_z_q;
	assign q = onx ? qx_q : qz_q;

	logic [SLOT_BITS-1:0] nlast, nmid;
	logic [SLOT_BITS:0] lohi;
	assign nlast = SLOT_BITS'(n_pts - 1'b1);
	always_comb begin
		lohi = {1'b0, lo_q} + {1'b0, hi_q};
		nmid = lohi[SLOT_BITS:1];
	end

	logic [SLOT_BITS:0] step_id;
	logic [npsa_pkg::IDX_BITS+SLOT_BITS:0] g0, g1;
	logic [SLOT_BITS-1:0] wid;
	always_comb begin
		g0 = (line_q * n_pts) + rd_id_q;
		step_id = {1'b0, rd_id_q} + 1'b1;
		wid = (step_id >= n_pts) ? '0 : step_id[SLOT_BITS-1:0];
		g1 = (line_q * n_pts) + wid;
		id_phase = (g0[npsa_pkg::IDX_BITS-1:0] == prev_q);
	end

	assign sts.bs_done = bs_done_q;
	assign sts.scan_stop = (ax >= best_q);
	assign sts.down_last = (ptr_q == '0);
	assign sts.up_empty = ({1'b0, mid_q} + 1'b1 >= n_pts);
	assign sts.up_last = ({1'b0, ptr_q} + 1'b1 >= n_pts);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= '0;
			res_valid <= 1'b0;
			bs_done_q <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			tail_q <= {tail_q[1:0], 1'b0};
			case (dcmd.op)
				npsa_pkg::OP_LATCH: begin
					line_q <= line_in;
					qx_q <= x_in;
					qz_q <= z_in;
					prev_q <= prev_in;
					lo_q <= '0;
					hi_q <= nlast;
					mid_q <= SLOT_BITS'(nlast >> 1);
					ptr_q <= SLOT_BITS'(nlast >> 1);
					bs_done_q <= 1'b0;
					best_q <= SQW'(npsa_pkg::START_LIMIT);
				end
				npsa_pkg::OP_BSTEP: begin
					if (v == q) begin
						bs_done_q <= 1'b1;
					end else begin
						logic [SLOT_BITS-1:0] nl, nh;
						logic [SLOT_BITS:0] s;
						nl = (v < q) ? mid_q : lo_q;
						nh = (v > q) ? mid_q : hi_q;
						s = {1'b0, nl} + {1'b0, nh};
						lo_q <= nl;
						hi_q <= nh;
						mid_q <= s[SLOT_BITS:1];
						ptr_q <= s[SLOT_BITS:1];
						if (s[SLOT_BITS:1] == mid_q) bs_done_q <= 1'b1;
					end
				end
				npsa_pkg::OP_SCAN: begin
					if (ax < best_q && dd < best_q) begin
						best_q <= dd;
						best_slot_q <= ptr_q;
					end
				end
				npsa_pkg::OP_ID: tail_q <= 3'b001;
				default: ;
			endcase
			if (dcmd.scan_init) begin
				ptr_q <= dcmd.scan_up ? mid_q + 1'b1 : mid_q;
				if (!dcmd.scan_up) best_slot_q <= mid_q;
			end else if (dcmd.op == npsa_pkg::OP_SCAN) begin
				if (dcmd.scan_up) ptr_q <= ptr_q + 1'b1;
				else if (ptr_q != '0) ptr_q <= ptr_q - 1'b1;
			end
			// tail: once the id is valid, compute the final id; then read the point by that id
			if (tail_q[0]) begin
				if (id_phase) begin
					fid_q <= wid;
					res_index <= g1[npsa_pkg::IDX_BITS-1:0];
				end else begin
					fid_q <= rd_id_q;
					res_index <= g0[npsa_pkg::IDX_BITS-1:0];
				end
			end
			if (tail_q[2]) begin
				res_valid <= 1'b1;
				res_x <= rd_pt_q[3*COORD_BITS-1:2*COORD_BITS];
				res_y <= rd_pt_q[2*COORD_BITS-1:COORD_BITS];
				res_z <= rd_pt_q[COORD_BITS-1:0];
				res_dist <= (best_q > SQW'({DW{1'b1}})) ? {DW{1'b1}} : DW'(best_q);
			end
		end
	end
endmodule
